// ===== sv/tss_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, states and fixed-point helpers for the tridiagonal solver.
// No dependencies; used by every module of the block.
package tss_pkg;

  localparam int unsigned DataW = 32;
  localparam logic signed [DataW-1:0] QMax = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] QMin = 32'sh8000_0000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_C,
    S_MUL_D,
    S_PIV,
    S_DC_GO,
    S_DC_WAIT,
    S_DD_GO,
    S_DD_WAIT,
    S_WRITE,
    S_BS_INIT,
    S_BS_RD,
    S_BS_MUL,
    S_BS_CALC,
    S_BS_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic drop;
    logic mul_c;
    logic mul_d;
    logic piv;
    logic div_go;
    logic div_sel_d;
    logic cap_c;
    logic cap_d;
    logic write;
    logic bs_init;
    logic bs_read;
    logic bs_mul;
    logic bs_calc;
    logic bs_next;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic last;
    logic div_done;
    logic bs_zero;
  } status_t;

  // Floor shift of a full product, then clamp to 32 bits.
  function automatic logic signed [DataW-1:0] sat_shift(input logic signed [63:0] p,
                                                        input int unsigned f);
    logic signed [63:0] s;
    s = p >>> f;
    if (s > 64'sh0000_0000_7FFF_FFFF) return QMax;
    if (s < -64'sh0000_0000_8000_0000) return QMin;
    return s[DataW-1:0];
  endfunction

  function automatic logic signed [DataW-1:0] sat_sub(input logic signed [DataW-1:0] x,
                                                      input logic signed [DataW-1:0] y);
    logic signed [DataW:0] s;
    s = {x[DataW-1], x} - {y[DataW-1], y};
    if (s[DataW] != s[DataW-1]) return s[DataW] ? QMin : QMax;
    return s[DataW-1:0];
  endfunction

endpackage

// ===== sv/tss_div.sv =====
`timescale 1ns / 1ps
// Iterative restoring divider: (num << FRAC_BITS) / den, truncated, saturated.
// Depends on tss_pkg.
module tss_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [tss_pkg::DataW-1:0] num_i,
  input  logic signed [tss_pkg::DataW-1:0] den_i,
  output logic                            done_o,
  output logic signed [tss_pkg::DataW-1:0] quo_o
);
  localparam int unsigned W  = tss_pkg::DataW + FRAC_BITS;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]                    dvd_q, dvd_d;
  logic [tss_pkg::DataW-1:0]       dvs_q;
  logic [tss_pkg::DataW:0]         rem_q, rem_d, tmp;
  logic [CW-1:0]                   cnt_q;
  logic                            busy_q, neg_q, done_q;
  logic signed [tss_pkg::DataW-1:0] quo_q;
  logic [tss_pkg::DataW-1:0]       num_mag, den_mag;
  logic [W-1:0]                    q_neg;
  logic                            ge;

  assign num_mag = num_i[tss_pkg::DataW-1] ? 32'(-num_i) : 32'(num_i);
  assign den_mag = den_i[tss_pkg::DataW-1] ? 32'(-den_i) : 32'(den_i);

  always_comb begin
    tmp   = {rem_q[tss_pkg::DataW-1:0], dvd_q[W-1]};
    ge    = tmp >= {1'b0, dvs_q};
    rem_d = ge ? tmp - {1'b0, dvs_q} : tmp;
    dvd_d = {dvd_q[W-2:0], ge};
    q_neg = -dvd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (den_i == '0) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= CW'(W);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {num_mag, {FRAC_BITS{1'b0}}};
      dvs_q <= den_mag;
      rem_q <= '0;
      neg_q <= num_i[tss_pkg::DataW-1] ^ den_i[tss_pkg::DataW-1];
      // Zero pivot: clamp by the sign of the numerator.
      if (den_i == '0) begin
        if (num_i == '0) quo_q <= '0;
        else quo_q <= num_i[tss_pkg::DataW-1] ? tss_pkg::QMin : tss_pkg::QMax;
      end
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end else if (cnt_q == '0 && !done_q && dvs_q != '0) begin
      quo_q <= quo_q;
    end
  end

  // Sign and clamp the magnitude quotient.
  always_comb begin
    quo_o = quo_q;
    if (dvs_q != '0) begin
      if (neg_q) begin
        quo_o = (dvd_q > W'(33'h1_0000_0000 >> 1)) ? tss_pkg::QMin : q_neg[tss_pkg::DataW-1:0];
      end else begin
        quo_o = (dvd_q > W'(32'h7FFF_FFFF)) ? tss_pkg::QMax : dvd_q[tss_pkg::DataW-1:0];
      end
    end
  end

  assign done_o = done_q;

endmodule

// ===== sv/tss_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: row registers, shared multiplier, divider, row stores, output.
// Depends on tss_pkg and tss_div.
module tss_datapath #(
  parameter int unsigned MAX_ROWS  = 64,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tss_pkg::cmd_t                    cmd_i,
  output tss_pkg::status_t                 status_o,
  input  logic signed [tss_pkg::DataW-1:0] sub_diag_i,
  input  logic signed [tss_pkg::DataW-1:0] diag_i,
  input  logic signed [tss_pkg::DataW-1:0] super_diag_i,
  input  logic signed [tss_pkg::DataW-1:0] rhs_i,
  input  logic                             last_row_i,
  output logic signed [tss_pkg::DataW-1:0] solution_o,
  output logic [5:0]                       row_index_o,
  output logic                             last_out_o,
  output logic [1:0]                       error_code_o
);
  localparam int unsigned AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW = $clog2(MAX_ROWS + 1);
  localparam int unsigned DW = tss_pkg::DataW;

  logic signed [DW-1:0] a_q, b_q, c_q, d_q;
  logic                 last_q;
  logic signed [DW-1:0] prev_c_q, prev_d_q, mc_q, piv_q, nd_q, cq_q, dq_q;
  logic signed [63:0]   prod_q;
  logic signed [DW-1:0] mul_x, mul_y, x_new;
  logic [CW-1:0]        count_q;
  logic [1:0]           err_q;
  logic [AW-1:0]        bs_r_q;
  logic                 bs_first_q;
  logic signed [DW-1:0] x_q, rd_c_q, rd_d_q;
  logic signed [DW-1:0] mem_c [MAX_ROWS];
  logic signed [DW-1:0] mem_d [MAX_ROWS];
  logic                 div_done;
  logic signed [DW-1:0] div_quo;

  tss_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i,
    .rst_ni,
    .start_i(cmd_i.div_go),
    .num_i  (cmd_i.div_sel_d ? nd_q : c_q),
    .den_i  (piv_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_comb begin
    mul_x = cmd_i.bs_mul ? rd_c_q : a_q;
    if (cmd_i.bs_mul) mul_y = x_q;
    else if (count_q == '0) mul_y = '0;
    else mul_y = cmd_i.mul_c ? prev_c_q : prev_d_q;
    x_new = bs_first_q ? rd_d_q
                       : tss_pkg::sat_sub(rd_d_q, tss_pkg::sat_shift(prod_q, FRAC_BITS));
  end

  assign status_o.full     = (count_q == CW'(MAX_ROWS));
  assign status_o.last     = last_q;
  assign status_o.div_done = div_done;
  assign status_o.bs_zero  = (bs_r_q == '0);

  // Control state: fill count and error flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      err_q   <= '0;
    end else if (cmd_i.clear) begin
      count_q <= '0;
      err_q   <= '0;
    end else begin
      if (cmd_i.drop) err_q[1] <= 1'b1;
      if (cmd_i.write) begin
        count_q <= count_q + 1'b1;
        if (piv_q == '0) err_q[0] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q    <= sub_diag_i;
      b_q    <= diag_i;
      c_q    <= super_diag_i;
      d_q    <= rhs_i;
      last_q <= last_row_i;
    end
    if (cmd_i.mul_c || cmd_i.mul_d || cmd_i.bs_mul) prod_q <= mul_x * mul_y;
    if (cmd_i.mul_d) mc_q <= tss_pkg::sat_shift(prod_q, FRAC_BITS);
    if (cmd_i.piv) begin
      piv_q <= tss_pkg::sat_sub(b_q, mc_q);
      nd_q  <= tss_pkg::sat_sub(d_q, tss_pkg::sat_shift(prod_q, FRAC_BITS));
    end
    if (cmd_i.cap_c) cq_q <= div_quo;
    if (cmd_i.cap_d) dq_q <= div_quo;
    if (cmd_i.write) begin
      mem_c[count_q[AW-1:0]] <= last_q ? '0 : cq_q;
      mem_d[count_q[AW-1:0]] <= dq_q;
      prev_c_q <= last_q ? '0 : cq_q;
      prev_d_q <= dq_q;
    end
    if (cmd_i.bs_init) begin
      bs_r_q     <= AW'(count_q - 1'b1);
      bs_first_q <= 1'b1;
    end
    if (cmd_i.bs_next) begin
      bs_r_q     <= bs_r_q - 1'b1;
      bs_first_q <= 1'b0;
    end
    if (cmd_i.bs_read) begin
      rd_c_q <= mem_c[bs_r_q];
      rd_d_q <= mem_d[bs_r_q];
    end
    if (cmd_i.bs_calc) begin
      x_q          <= x_new;
      solution_o   <= x_new;
      row_index_o  <= 6'(bs_r_q);
      last_out_o   <= (bs_r_q == '0);
      error_code_o <= err_q;
    end
  end

endmodule

// ===== sv/tss_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: sequences elimination and back substitution.
// Depends on tss_pkg.
module tss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              last_row_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  tss_pkg::status_t  status_i,
  output tss_pkg::cmd_t     cmd_o
);
  tss_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= tss_pkg::S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tss_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (!status_i.full) state_d = tss_pkg::S_MUL_C;
          else if (last_row_i) state_d = tss_pkg::S_BS_INIT;
        end
      end
      tss_pkg::S_MUL_C:   state_d = tss_pkg::S_MUL_D;
      tss_pkg::S_MUL_D:   state_d = tss_pkg::S_PIV;
      tss_pkg::S_PIV:     state_d = status_i.last ? tss_pkg::S_DD_GO : tss_pkg::S_DC_GO;
      tss_pkg::S_DC_GO:   state_d = tss_pkg::S_DC_WAIT;
      tss_pkg::S_DC_WAIT: if (status_i.div_done) state_d = tss_pkg::S_DD_GO;
      tss_pkg::S_DD_GO:   state_d = tss_pkg::S_DD_WAIT;
      tss_pkg::S_DD_WAIT: if (status_i.div_done) state_d = tss_pkg::S_WRITE;
      tss_pkg::S_WRITE:   state_d = status_i.last ? tss_pkg::S_BS_INIT : tss_pkg::S_IDLE;
      tss_pkg::S_BS_INIT: state_d = tss_pkg::S_BS_RD;
      tss_pkg::S_BS_RD:   state_d = tss_pkg::S_BS_MUL;
      tss_pkg::S_BS_MUL:  state_d = tss_pkg::S_BS_CALC;
      tss_pkg::S_BS_CALC: state_d = tss_pkg::S_BS_OUT;
      tss_pkg::S_BS_OUT: begin
        if (out_ready_i) state_d = status_i.bs_zero ? tss_pkg::S_IDLE : tss_pkg::S_BS_RD;
      end
      default: state_d = tss_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      tss_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        cmd_o.drop = in_valid_i && status_i.full;
      end
      tss_pkg::S_MUL_C:   cmd_o.mul_c = 1'b1;
      tss_pkg::S_MUL_D:   cmd_o.mul_d = 1'b1;
      tss_pkg::S_PIV:     cmd_o.piv = 1'b1;
      tss_pkg::S_DC_GO:   cmd_o.div_go = 1'b1;
      tss_pkg::S_DC_WAIT: cmd_o.cap_c = status_i.div_done;
      tss_pkg::S_DD_GO: begin
        cmd_o.div_go    = 1'b1;
        cmd_o.div_sel_d = 1'b1;
      end
      tss_pkg::S_DD_WAIT: cmd_o.cap_d = status_i.div_done;
      tss_pkg::S_WRITE:   cmd_o.write = 1'b1;
      tss_pkg::S_BS_INIT: cmd_o.bs_init = 1'b1;
      tss_pkg::S_BS_RD:   cmd_o.bs_read = 1'b1;
      tss_pkg::S_BS_MUL:  cmd_o.bs_mul = 1'b1;
      tss_pkg::S_BS_CALC: cmd_o.bs_calc = 1'b1;
      tss_pkg::S_BS_OUT: begin
        out_valid_o   = 1'b1;
        cmd_o.bs_next = out_ready_i && !status_i.bs_zero;
        cmd_o.clear   = out_ready_i && status_i.bs_zero;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== sv/tridiagonal_system_solver.sv =====
`timescale 1ns / 1ps
// Tridiagonal system solver (Thomas algorithm), signed fixed point, top level.
// Depends on tss_pkg, tss_ctrl, tss_datapath (and tss_div below it).
//
// Usage: send one row per input item (sub_diag, diag, super_diag, rhs) over
// the in_valid_i/in_ready_o channel, row 0 first; set last_row_i on the final
// row. Forward elimination runs as each row arrives. After the last row, the
// block emits one item per stored row on out_valid_o/out_ready_i, from the highest
// row down to row 0; last_out_o marks row 0 and error_code_o carries the
// run's flags (bit 0 zero pivot, bit 1 rows dropped beyond MAX_ROWS).
// A stored row's time is set by the bit-serial divider, which runs twice
// per row; the last row runs it once, and a dropped row does not run it.
// Back substitution runs the store read, multiplier, calculation and output
// states for each result, after the start state.
// A stalled receiver holds the result register and the whole sequencer; no
// new row is taken until the run's last result is accepted.
// Reset clears the controller, the fill count and the flags; the row stores
// need no clearing.
module tridiagonal_system_solver #(
  parameter int unsigned MAX_ROWS  = 64,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] sub_diag_i,
  input  logic signed [31:0] diag_i,
  input  logic signed [31:0] super_diag_i,
  input  logic signed [31:0] rhs_i,
  input  logic               last_row_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] solution_o,
  output logic [5:0]         row_index_o,
  output logic               last_out_o,
  output logic [1:0]         error_code_o
);
  tss_pkg::cmd_t    cmd;
  tss_pkg::status_t status;

  // Sequencer: one row at a time, then the back-substitution sweep.
  tss_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .last_row_i,
    .in_ready_o,
    .out_valid_o,
    .out_ready_i,
    .status_i(status),
    .cmd_o   (cmd)
  );

  // Arithmetic, row stores and the result register.
  tss_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i   (cmd),
    .status_o(status),
    .sub_diag_i,
    .diag_i,
    .super_diag_i,
    .rhs_i,
    .last_row_i,
    .solution_o,
    .row_index_o,
    .last_out_o,
    .error_code_o
  );

  // No row is taken while a result is on offer.
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> !in_ready_o)
    else $error("input ready while result pending");

  // Delivering row 0 ends the run and frees the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_out_o |=> in_ready_o)
    else $error("run did not end after row zero");

  // Each further result needs a fresh store read, so no back-to-back results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_out_o |=> !out_valid_o)
    else $error("result shown without back-substitution step");

  // Divider completions only land while the sequencer waits for them.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.div_done |-> !in_ready_o && !out_valid_o)
    else $error("divider completed outside a wait state");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for tridiagonal_system_solver.
// Depends on the block's RTL only; predicts every solution item in fixed point.
module tb;

  localparam int unsigned MaxRows = 64;
  localparam int unsigned FracBits = 16;
  localparam logic signed [31:0] QHi = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] QLo = 32'sh8000_0000;
  localparam logic signed [31:0] QOne = 32'sh0001_0000;

  // Error code bits as carried on error_code_o.
  localparam logic [1:0] ErrPivot = 2'b01;
  localparam logic [1:0] ErrDrop  = 2'b10;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [31:0] d;
    logic               last;
  } row_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic [5:0]         idx;
    logic               fin;
    logic [1:0]         err;
  } sol_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] sub_diag_i = '0;
  logic signed [31:0] diag_i = '0;
  logic signed [31:0] super_diag_i = '0;
  logic signed [31:0] rhs_i = '0;
  logic               last_row_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] solution_o;
  logic [5:0]         row_index_o;
  logic               last_out_o;
  logic [1:0]         error_code_o;

  tridiagonal_system_solver #(.MAX_ROWS(MaxRows), .FRAC_BITS(FracBits)) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: eliminated super diagonal and right side per row.
  logic signed [31:0] cp_mem [MaxRows];
  logic signed [31:0] dp_mem [MaxRows];
  int unsigned        fill;
  logic [1:0]         flags;

  row_t pending_rows[$];
  sol_t expected_sols[$];
  int   n_fail = 0;

  // Idling knobs: percent of cycles the sender idles and the receiver stalls.
  int  gap_pct = 0;
  int  stall_pct = 0;
  bit  hold_start = 1'b0;
  bit  hold_on = 1'b0;

  function automatic logic signed [31:0] clamp64(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return QHi;
    if (v < -64'sd2147483648) return QLo;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] x,
                                                input logic signed [31:0] y);
    logic signed [63:0] p;
    p = 64'(x) * 64'(y);
    return clamp64(p >>> FracBits);
  endfunction

  function automatic logic signed [31:0] fx_sub(input logic signed [31:0] x,
                                                input logic signed [31:0] y);
    return clamp64(64'(x) - 64'(y));
  endfunction

  // Quotient with zero-pivot handling; flags a zero denominator.
  function automatic logic signed [31:0] fx_div(input logic signed [31:0] n,
                                                input logic signed [31:0] dn);
    logic signed [63:0] q;
    if (dn == 0) begin
      flags |= ErrPivot;
      if (n > 0) return QHi;
      if (n < 0) return QLo;
      return '0;
    end
    q = (64'(n) <<< FracBits) / 64'(dn);
    return clamp64(q);
  endfunction

  // Forward-eliminate one row; on the last row queue the back substitution.
  task automatic solve_row(input row_t r);
    logic signed [31:0] piv, nd, x;
    int unsigned i, k, n;
    sol_t s;
    if (fill >= MaxRows) begin
      flags |= ErrDrop;
    end else begin
      i = fill;
      if (i == 0) begin
        piv = r.b;
        nd = r.d;
      end else begin
        piv = fx_sub(r.b, fx_mul(r.a, cp_mem[i-1]));
        nd = fx_sub(r.d, fx_mul(r.a, dp_mem[i-1]));
      end
      cp_mem[i] = r.last ? '0 : fx_div(r.c, piv);
      dp_mem[i] = fx_div(nd, piv);
      fill = i + 1;
    end
    if (!r.last) return;
    n = fill;
    x = '0;
    for (k = 0; k < n; k++) begin
      i = n - 1 - k;
      x = (k == 0) ? dp_mem[i] : fx_sub(dp_mem[i], fx_mul(cp_mem[i], x));
      s.x = x;
      s.idx = i[5:0];
      s.fin = (i == 0);
      s.err = flags;
      expected_sols.push_back(s);
    end
    fill = 0;
    flags = '0;
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
    n_fail++;
  endtask

  // Driver: offer the next item at the falling edge, hold it until accepted.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_ready_o) begin
        // hold
      end else if (pending_rows.size() > 0 && $urandom_range(99) >= gap_pct) begin
        in_valid_i   <= 1'b1;
        sub_diag_i   <= pending_rows[0].a;
        diag_i       <= pending_rows[0].b;
        super_diag_i <= pending_rows[0].c;
        rhs_i        <= pending_rows[0].d;
        last_row_i   <= pending_rows[0].last;
      end else begin
        in_valid_i <= 1'b0;
      end
      if (hold_on) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Long receiver hold, counted in its own process.
  initial begin
    wait (hold_start);
    @(negedge clk_i);
    hold_on <= 1'b1;
    repeat (3000) @(negedge clk_i);
    hold_on <= 1'b0;
  end

  // Monitor: predict on input accepts, compare on output accepts.
  always @(posedge clk_i) begin
    sol_t e;
    if (rst_ni && in_valid_i && in_ready_o) begin
      solve_row(pending_rows.pop_front());
      // Drop valid so the next negedge decides afresh; the driver re-offers.
      in_valid_i <= 1'b0;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_sols.size() == 0) begin
        report("unexpected item", {32'b0, solution_o}, '0);
      end else begin
        e = expected_sols.pop_front();
        if (solution_o !== e.x) report("solution", 64'(solution_o), 64'(e.x));
        if (row_index_o !== e.idx) report("row_index", 64'(row_index_o), 64'(e.idx));
        if (last_out_o !== e.fin) report("last_out", 64'(last_out_o), 64'(e.fin));
        if (error_code_o !== e.err) report("error_code", 64'(error_code_o), 64'(e.err));
      end
    end
  end

  function automatic logic signed [31:0] rnd_coef();
    case ($urandom_range(9))
      0: return QHi;
      1: return QLo;
      2: return '0;
      3: return $urandom;
      default: return 32'($signed($urandom_range(32'h0008_0000))) - 32'sh0004_0000;
    endcase
  endfunction

  // Queue one system of n rows; dominant diagonals mostly, random noise sometimes.
  task automatic push_system(input int n, input bit wild);
    row_t r;
    for (int i = 0; i < n; i++) begin
      r.a = rnd_coef();
      r.c = rnd_coef();
      r.d = rnd_coef();
      r.b = wild ? rnd_coef() : 32'(QOne * 4 + $urandom_range(32'h0004_0000));
      if (!wild && $urandom_range(1)) r.b = -r.b;
      r.last = (i == n - 1);
      pending_rows.push_back(r);
    end
  endtask

  task automatic drain();
    while (pending_rows.size() > 0 || expected_sols.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  initial begin
    row_t r;
    fill = 0;
    flags = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed: single row, zero pivots of each sign, extremes, overflow.
    r = '{a: QHi, b: QOne * 2, c: QHi, d: QOne * 3, last: 1'b1};
    pending_rows.push_back(r);
    r = '{a: '0, b: '0, c: QOne, d: QOne, last: 1'b0};
    pending_rows.push_back(r);
    r = '{a: QOne, b: QOne, c: QLo, d: QLo, last: 1'b0};
    pending_rows.push_back(r);
    r = '{a: QLo, b: '0, c: '0, d: '0, last: 1'b1};
    pending_rows.push_back(r);
    r = '{a: QLo, b: 32'sd1, c: QLo, d: QHi, last: 1'b0};
    pending_rows.push_back(r);
    r = '{a: QHi, b: QLo, c: QHi, d: QLo, last: 1'b1};
    pending_rows.push_back(r);
    r = '{a: '0, b: -QOne, c: 32'sh5555_AAAA, d: 32'shAAAA_5555, last: 1'b1};
    pending_rows.push_back(r);
    push_system(3, 1'b1);
    drain();

    // Capacity: fill all rows, then drop two more including the last.
    push_system(MaxRows + 2, 1'b0);
    drain();

    // Random systems across idling phases; a long receiver hold in one.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 85; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 85; end
        default: begin gap_pct = 27; stall_pct = 27; end
      endcase
      for (int s = 0; s < 7; s++) push_system($urandom_range(1, 8), $urandom_range(3) == 0);
      if (ph == 0) hold_start = 1'b1;
      drain();
    end

    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: slow divider with long stalls still finishes well inside this.
  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
